>>> src/felc_pkg.sv
`timescale 1ns / 1ps
package felc_pkg;
	localparam int DEPTH      = 64;
	localparam int START_BITS = 32;
	localparam int SIZE_BITS  = 8;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_INDEX = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	typedef struct packed {
		logic [START_BITS-1:0] start;
		logic [SIZE_BITS-1:0]  size;
	} extent_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [START_BITS-1:0] extent_start;
		logic [SIZE_BITS-1:0]  extent_size;
		logic [IDX_BITS-1:0]   entry_index;
	} req_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   slot;
		logic [START_BITS-1:0] slot_start;
		logic [SIZE_BITS-1:0]  slot_size;
		logic [CNT_BITS-1:0]   entry_count;
		logic [1:0]            status;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                  ins;   // shift up from idx, write new at idx
		logic                  del;   // shift down from idx
		logic                  wr;    // overwrite at idx
		logic [IDX_BITS-1:0]   idx;
		extent_t               ext;
	} cell_cmd_t;
endpackage

>>> src/felc_if.sv
`timescale 1ns / 1ps
interface felc_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/felc_cell.sv
`timescale 1ns / 1ps
// One table entry. Takes its lower neighbour on insert, its upper one on delete.
module felc_cell (
	input  logic               clk,
	input  felc_pkg::cell_cmd_t cmd,
	input  logic [felc_pkg::IDX_BITS-1:0] my_idx,
	input  felc_pkg::extent_t  lower,
	input  felc_pkg::extent_t  upper,
	output felc_pkg::extent_t  ent
);
	import felc_pkg::*;
	extent_t ent_q;
	assign ent = ent_q;
	always_ff @(posedge clk) begin
		if (cmd.ins && my_idx == cmd.idx) ent_q <= cmd.ext;
		else if (cmd.ins && my_idx > cmd.idx) ent_q <= lower;
		else if (cmd.del && my_idx >= cmd.idx) ent_q <= upper;
		else if (cmd.wr && my_idx == cmd.idx) ent_q <= cmd.ext;
	end
endmodule

>>> src/felc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for an insert: find slot, shift, then up to two merges, each merge one delete.
module felc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	felc_if.sink               req,
	felc_if.source             rsp,
	input  felc_pkg::extent_t  tbl [felc_pkg::DEPTH],
	output felc_pkg::cell_cmd_t cmd
);
	import felc_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_SUCC = 3'd1, S_PRED = 3'd2,
		S_DONE = 3'd3, S_OUT = 3'd4;
	logic [2:0]          state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [IDX_BITS-1:0] pos_q;
	logic [1:0]          st_q;
	rsp_t                rsp_q;
	logic [IDX_BITS-1:0] pos_c;
	logic [SIZE_BITS:0]  sum_c;
	logic                touch_c;
	extent_t             lo_c, hi_c;
	logic [IDX_BITS-1:0] pos_m1;
	// Merges are a write of the sum then a delete of the absorbed entry.
	logic                del_pend_q;
	logic [IDX_BITS-1:0] del_idx_q;

	// Insert position: one past the highest valid entry whose start is below the new one.
	always_comb begin
		logic [CNT_BITS-1:0] n;
		n = '0;
		for (int i = 0; i < DEPTH; i++)
			if (CNT_BITS'(i) < cnt_q && tbl[i].start < req.data.extent_start)
				n = CNT_BITS'(i + 1);
		pos_c = n[IDX_BITS-1:0];
	end

	assign pos_m1 = pos_q - 1'b1;
	always_comb begin
		lo_c = (state_q == S_SUCC) ? tbl[pos_q] : tbl[pos_m1];
		hi_c = (state_q == S_SUCC) ? tbl[IDX_BITS'(pos_q + 1'b1)] : tbl[pos_q];
		touch_c = ({1'b0, lo_c.start} + {{(START_BITS-SIZE_BITS+1){1'b0}}, lo_c.size})
			== {1'b0, hi_c.start};
		sum_c = {1'b0, lo_c.size} + {1'b0, hi_c.size};
	end

	assign req.ready = (state_q == S_IDLE) && !rsp.valid;
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = rsp_q;

	// A pending delete goes out on its own before any further merge check.
	always_comb begin
		cmd = '0;
		if (del_pend_q) begin
			cmd.del = 1'b1;
			cmd.idx = del_idx_q;
		end else if (state_q == S_IDLE && req.valid && req.ready) begin
			unique case (req.data.op)
				OP_INSERT: begin
					cmd.ins = (cnt_q < CNT_BITS'(DEPTH));
					cmd.idx = pos_c;
				end
				OP_REMOVE: begin
					cmd.del = ({1'b0, req.data.entry_index} < cnt_q);
					cmd.idx = req.data.entry_index;
				end
				OP_UPDATE: begin
					cmd.wr  = ({1'b0, req.data.entry_index} < cnt_q);
					cmd.idx = req.data.entry_index;
				end
				default: cmd.idx = req.data.entry_index;
			endcase
			cmd.ext = '{req.data.extent_start, req.data.extent_size};
		end else if (state_q == S_SUCC &&
				{1'b0, pos_q} + 1'b1 < cnt_q && touch_c && !sum_c[SIZE_BITS]) begin
			cmd.wr = 1'b1; cmd.idx = pos_q; cmd.ext = '{lo_c.start, sum_c[SIZE_BITS-1:0]};
		end else if (state_q == S_PRED &&
				pos_q != '0 && touch_c && !sum_c[SIZE_BITS]) begin
			cmd.wr = 1'b1; cmd.idx = pos_m1; cmd.ext = '{lo_c.start, sum_c[SIZE_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			del_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					st_q <= ST_OK;
					if (req.data.op == OP_INSERT) begin
						if (cnt_q >= CNT_BITS'(DEPTH)) begin
							rsp_q <= '{'0, '0, '0, cnt_q, ST_FULL};
							state_q <= S_OUT;
						end else begin
							pos_q <= pos_c;
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_SUCC;
						end
					end else begin
						pos_q <= req.data.entry_index;
						if ({1'b0, req.data.entry_index} >= cnt_q) begin
							rsp_q <= '{req.data.entry_index, '0, '0, cnt_q, ST_INDEX};
							state_q <= S_OUT;
						end else begin
							if (req.data.op == OP_REMOVE) cnt_q <= cnt_q - 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_SUCC: begin
					if ({1'b0, pos_q} + 1'b1 < cnt_q && touch_c) begin
						if (sum_c[SIZE_BITS]) st_q <= ST_OVF;
						else begin
							del_pend_q <= 1'b1; del_idx_q <= IDX_BITS'(pos_q + 1'b1);
						end
					end
					state_q <= S_PRED;
				end
				S_PRED: begin
					if (del_pend_q) begin
						del_pend_q <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						if (pos_q != '0 && touch_c) begin
							if (sum_c[SIZE_BITS]) st_q <= ST_OVF;
							else begin
								del_pend_q <= 1'b1; del_idx_q <= pos_q;
								pos_q <= pos_m1;
							end
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (del_pend_q) begin
						del_pend_q <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						rsp_q.slot <= pos_q;
						rsp_q.entry_count <= cnt_q;
						rsp_q.status <= st_q;
						if ({1'b0, pos_q} < cnt_q) begin
							rsp_q.slot_start <= tbl[pos_q].start;
							rsp_q.slot_size  <= tbl[pos_q].size;
						end else begin
							rsp_q.slot_start <= '0;
							rsp_q.slot_size  <= '0;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> src/free_extent_list_coalescing_top.sv
`timescale 1ns / 1ps
// Sorted free-extent table built as a chain of 64 cells. One request is in
// flight at a time. An insert passes through slot search and shift, a
// successor merge check, a predecessor merge check and the result load, with
// an extra delete step for each merge that happens to shift the absorbed entry
// out of the chain. A remove, update or read passes through the result load
// only, and a rejected request (full table or bad index) goes straight to its
// result beat. A new request is taken from the cycle after the result beat.
module free_extent_list_coalescing_top (
	input logic clk,
	input logic arst_n,
	felc_if.sink   in_ch,
	felc_if.source out_ch
);
	import felc_pkg::*;
	extent_t   tbl [DEPTH];
	cell_cmd_t cmd;
	felc_if #(.payload_t(req_t)) req_i ();

	assign req_i.valid = in_ch.valid;
	assign req_i.data  = in_ch.data;
	assign in_ch.ready = req_i.ready;

	felc_ctrl u_ctrl (.clk, .arst_n, .req(req_i), .rsp(out_ch), .tbl, .cmd(cmd));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		felc_cell u_cell (
			.clk, .cmd, .my_idx(IDX_BITS'(i)),
			.lower(tbl[(i + DEPTH - 1) % DEPTH]),
			.upper(tbl[(i + 1) % DEPTH]),
			.ent(tbl[i])
		);
	end
endmodule

>>> src/felc_checker.sv
`timescale 1ns / 1ps
module felc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid, in_ready, out_valid, out_ready,
	input logic [1:0] out_status,
	input logic [6:0] out_count
);
	import felc_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= 7'd64) else $error("count over depth");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> out_count == 7'(DEPTH))
		else $error("full reported below depth");
endmodule

bind free_extent_list_coalescing_top felc_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_status(out_ch.data.status), .out_count(out_ch.data.entry_count));

>>> tb/sv/free_extent_list_coalescing_top_tb.sv
`timescale 1ns / 1ps
module free_extent_list_coalescing_top_tb;
	import felc_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	int   n_errors;

	felc_if #(.payload_t(req_t)) req_ch ();
	felc_if #(.payload_t(rsp_t)) rsp_ch ();

	free_extent_list_coalescing_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch.sink),
		.out_ch (rsp_ch.source)
	);

	task automatic report_mismatch(string what, longint got, longint wanted);
		$display("mismatch %s: got %0h wanted %0h at %0t", what, got, wanted, $realtime);
		n_errors++;
	endtask

	// Predicts the responses of the sorted free-extent table and holds them in order.
	class extent_table_scoreboard;
		extent_t       entries[DEPTH];
		int            n_valid;
		rsp_t          pending[$];

		function new();
			n_valid = 0;
			foreach (entries[k]) entries[k] = '0;
		endfunction

		function void remove_at(int idx);
			for (int k = idx; k + 1 < n_valid; k++) entries[k] = entries[k + 1];
			n_valid--;
			entries[n_valid] = '0;
		endfunction

		// End is computed one bit wider so that nothing wraps round the address space.
		function bit abuts(extent_t lo, extent_t hi);
			return ({1'b0, lo.start} + lo.size) == {1'b0, hi.start};
		endfunction

		function void note_request(req_t rq);
			rsp_t rs;
			int   pos;
			logic [SIZE_BITS:0] sum;
			rs = '0;
			if (rq.op == OP_INSERT) begin
				if (n_valid >= DEPTH) begin
					rs.status = ST_FULL;
				end else begin
					pos = n_valid;
					while (pos > 0 && !(entries[pos - 1].start < rq.extent_start)) pos--;
					for (int k = n_valid; k > pos; k--) entries[k] = entries[k - 1];
					entries[pos].start = rq.extent_start;
					entries[pos].size = rq.extent_size;
					n_valid++;
					rs.status = ST_OK;
					// Try the successor first, then the predecessor.
					if (pos + 1 < n_valid && abuts(entries[pos], entries[pos + 1])) begin
						sum = entries[pos].size + entries[pos + 1].size;
						if (sum[SIZE_BITS]) rs.status = ST_OVF;
						else begin
							entries[pos].size = sum[SIZE_BITS-1:0];
							remove_at(pos + 1);
						end
					end
					if (pos > 0 && abuts(entries[pos - 1], entries[pos])) begin
						sum = entries[pos - 1].size + entries[pos].size;
						if (sum[SIZE_BITS]) rs.status = ST_OVF;
						else begin
							entries[pos - 1].size = sum[SIZE_BITS-1:0];
							remove_at(pos);
							pos--;
						end
					end
					rs.slot = IDX_BITS'(pos);
					rs.slot_start = entries[pos].start;
					rs.slot_size = entries[pos].size;
				end
			end else begin
				rs.slot = rq.entry_index;
				if (rq.entry_index >= n_valid) begin
					rs.status = ST_INDEX;
				end else begin
					rs.status = ST_OK;
					if (rq.op == OP_REMOVE) remove_at(rq.entry_index);
					else if (rq.op == OP_UPDATE) begin
						entries[rq.entry_index].start = rq.extent_start;
						entries[rq.entry_index].size = rq.extent_size;
					end
					if (rq.entry_index < n_valid) begin
						rs.slot_start = entries[rq.entry_index].start;
						rs.slot_size = entries[rq.entry_index].size;
					end
				end
			end
			rs.entry_count = CNT_BITS'(n_valid);
			pending.push_back(rs);
		endfunction

		task check_response(rsp_t got);
			rsp_t exp_rs;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing pending", 0, 0);
				return;
			end
			exp_rs = pending.pop_front();
			if (got.slot !== exp_rs.slot)
				report_mismatch("slot", got.slot, exp_rs.slot);
			if (got.slot_start !== exp_rs.slot_start)
				report_mismatch("slot_start", got.slot_start, exp_rs.slot_start);
			if (got.slot_size !== exp_rs.slot_size)
				report_mismatch("slot_size", got.slot_size, exp_rs.slot_size);
			if (got.entry_count !== exp_rs.entry_count)
				report_mismatch("entry_count", got.entry_count, exp_rs.entry_count);
			if (got.status !== exp_rs.status)
				report_mismatch("status", got.status, exp_rs.status);
		endtask
	endclass

	extent_table_scoreboard sb;
	bit   idle_enable;
	int   quiet_cycles;
	logic [31:0] next_base;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("free_extent_list_coalescing_top_tb: errors");
			$finish;
		end
	end

	// Response side: random stalls, checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= !(idle_enable && $urandom_range(99) < 23);
		end
	end

	// Drives one request beat and waits for it to be taken. The block holds
	// ready low after a beat, so valid may stay high until the next request.
	task automatic send_request(logic [1:0] op, logic [31:0] st, logic [7:0] sz, logic [5:0] idx);
		req_t rq;
		rq.op = op;
		rq.extent_start = st;
		rq.extent_size = sz;
		rq.entry_index = idx;
		while (idle_enable && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= rq;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	// Wait until all expected responses have arrived.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Random index, mostly within the table, sometimes beyond it.
	function automatic logic [5:0] pick_index();
		if (sb.n_valid > 0 && $urandom_range(9) < 8) return 6'($urandom_range(sb.n_valid - 1));
		return 6'($urandom_range(63));
	endfunction

	initial begin
		int k;
		logic [31:0] st;
		logic [7:0] sz;
		n_errors = 0;
		quiet_cycles = 0;
		idle_enable = 1'b0;
		sb = new();
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: bad indexes on an empty table, merges, overflow, wrap and equal starts.
		send_request(OP_READ, 0, 0, 6'd0);
		send_request(OP_REMOVE, 0, 0, 6'd63);
		send_request(OP_UPDATE, 32'hFFFF_FFFF, 8'hFF, 6'd0);
		send_request(OP_INSERT, 32'd100, 8'd10, 0);
		send_request(OP_INSERT, 32'd120, 8'd5, 0);
		send_request(OP_INSERT, 32'd110, 8'd10, 0);
		send_request(OP_INSERT, 32'd125, 8'hFF, 0);
		send_request(OP_INSERT, 32'd125, 8'd3, 0);
		send_request(OP_INSERT, 32'hFFFF_FF00, 8'hFF, 0);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 0);
		send_request(OP_INSERT, 32'd0, 8'd0, 0);
		send_request(OP_INSERT, 32'd0, 8'd0, 0);
		send_request(OP_UPDATE, 32'hAAAA_5555, 8'hA5, 6'd1);
		send_request(OP_READ, 0, 0, 6'd1);
		send_request(OP_REMOVE, 0, 0, 6'd0);
		send_request(OP_REMOVE, 0, 0, 6'(sb.n_valid - 1));
		send_request(OP_READ, 0, 0, 6'd63);
		// Fill to capacity and try one more insert.
		while (sb.n_valid < DEPTH)
			send_request(OP_INSERT, 32'h1000_0000 + ($urandom_range(1000) * 300),
				8'($urandom_range(255)), 0);
		send_request(OP_INSERT, 32'h5555_AAAA, 8'h5A, 0);
		send_request(OP_READ, 0, 0, 6'd63);
		drain_responses();

		// Random: runs of adjoining frees mixed with removes, updates and reads.
		idle_enable = 1'b1;
		next_base = $urandom;
		for (k = 0; k < 570; k++) begin
			if (k == 200) idle_enable = 1'b0;
			if (k == 320) idle_enable = 1'b1;
			if (k == 400) drain_responses();
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					sz = $urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(64));
					case ($urandom_range(3))
						0: st = $urandom;
						1: st = next_base;
						default: st = (sb.n_valid > 0) ?
							sb.entries[$urandom_range(sb.n_valid - 1)].start - sz : next_base - sz;
					endcase
					next_base = st + sz;
					send_request(OP_INSERT, st, sz, 6'($urandom_range(63)));
				end
				4, 5: send_request(OP_REMOVE, $urandom, 8'($urandom_range(255)), pick_index());
				6: send_request(OP_UPDATE, $urandom, 8'($urandom_range(255)), pick_index());
				default: send_request(OP_READ, $urandom, 8'($urandom_range(255)), pick_index());
			endcase
		end
		drain_responses();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_errors == 0 && sb.pending.size() == 0)
			$display("free_extent_list_coalescing_top_tb: clean");
		else
			$display("free_extent_list_coalescing_top_tb: errors");
		$finish;
	end
endmodule
